FILE: sv/uxt_pkg.sv
// Shared types, constants and helpers for the UWB planar trilateration block.
package uxt_pkg;

    // anchor lanes; lanes at or above NUM_ANCHORS never count as valid
    localparam int NUM_ANCHORS = 4;
    localparam int N_LANE      = 4;
    localparam int LANE_W      = 2;
    localparam int CNT_W       = 3;
    localparam int MIN_ANCHORS = 3;

    localparam int W_R       = 17;
    localparam int W_CRD     = 16;
    localparam int W_POSREG  = 48;
    localparam int W_TAG     = 16;
    localparam int W_CFG_IDX = 3;

    // range projection and square root
    localparam int W_R2      = 33;
    localparam int W_DZ      = 18;
    localparam int W_DZ2     = 34;
    localparam int W_H2      = 35;
    localparam int W_SQ      = 32;
    localparam int W_HR      = 16;
    localparam int SQ_STAGES = 4;
    localparam int SQ_STEPS  = 4;

    // normal equations
    localparam int W_A  = 18;
    localparam int W_AA = 36;
    localparam int W_Q  = 32;
    localparam int W_C  = 34;
    localparam int W_AC = 52;
    localparam int W_S  = 38;
    localparam int W_T  = 54;

    // split multiplier
    localparam int MUL_SPLIT = 27;
    localparam int MUL_LAT   = 4;
    localparam int W_MAG     = W_T + W_S;
    localparam int W_NUM     = W_MAG + 2;

    // divider
    localparam int W_OUT      = 18;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = 6;
    localparam int W_DIV      = W_NUM + W_OUT;

    localparam int LINE_A = MUL_LAT + 1;
    localparam int LINE_B = DIV_STAGES + 2;

    localparam int NEG_LIMIT   = 50000;
    localparam int DET_MIN     = 1000;
    localparam int POS_MAX     = 131071;
    localparam int POS_MIN_MAG = 131072;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_SING = 2'd2;

    localparam logic [W_CFG_IDX-1:0] REG_ANCHOR0 = 3'd0;
    localparam logic [W_CFG_IDX-1:0] REG_ANCHOR1 = 3'd1;
    localparam logic [W_CFG_IDX-1:0] REG_ANCHOR2 = 3'd2;
    localparam logic [W_CFG_IDX-1:0] REG_ANCHOR3 = 3'd3;
    localparam logic [W_CFG_IDX-1:0] REG_TAG     = 3'd4;

    localparam logic [W_POSREG-1:0] ANCHOR0_RST = 48'h07D0_0000_0000;
    localparam logic [W_POSREG-1:0] ANCHOR1_RST = 48'h07D0_0708_0000;
    localparam logic [W_POSREG-1:0] ANCHOR2_RST = 48'h07D0_0000_0E10;
    localparam logic [W_POSREG-1:0] ANCHOR3_RST = 48'h07D0_0708_0E10;
    localparam logic [W_TAG-1:0]    TAG_RST     = 16'd1200;

    typedef struct packed {
        logic [W_SQ-1:0] n;
        logic [W_SQ-1:0] res;
    } t_sq;

    typedef struct packed {
        logic              vld;
        logic [N_LANE-1:0] mask;
    } t_front_side;

    typedef struct packed {
        logic              vld;
        logic [N_LANE-1:0] mask;
        logic              few;
    } t_acc_side;

    typedef struct packed {
        logic              vld;
        logic [N_LANE-1:0] mask;
        logic [1:0]        status;
    } t_side;

    // one digit of the bitwise integer square root, k = 0 is the top digit
    function automatic t_sq sq_step(input t_sq s, input int k);
        t_sq             o;
        logic [W_SQ-1:0] bt;
        logic [W_SQ-1:0] trial;
        bt    = W_SQ'(1) << (W_SQ - 2 - 2 * k);
        trial = s.res + bt;
        if (s.n >= trial) begin
            o.n   = s.n - trial;
            o.res = (s.res >> 1) + bt;
        end else begin
            o.n   = s.n;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    function automatic logic signed [W_NUM-1:0] sgn_mag(input logic [W_MAG-1:0] m,
                                                        input logic neg);
        logic signed [W_NUM-1:0] v;
        v = $signed({2'b00, m});
        return neg ? -v : v;
    endfunction

endpackage

FILE: sv/uxt_range.sv
// Range projection to the floor plane and pipelined integer square root per anchor.
module uxt_range import uxt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic signed [W_R-1:0]   i_dist [N_LANE],
    input  logic [W_POSREG-1:0]     i_pos  [N_LANE],
    input  logic [W_TAG-1:0]        i_tag,
    output t_front_side             o_side,
    output logic [W_HR-1:0]         o_hr   [N_LANE]
);

    logic signed [W_DZ-1:0]    dz   [N_LANE];
    logic signed [2*W_R-1:0]   rr   [N_LANE];
    logic signed [2*W_DZ-1:0]  dd   [N_LANE];
    logic signed [W_H2-1:0]    h2   [N_LANE];

    logic                      r_s0_vld;
    logic [W_R2-1:0]           r_r2   [N_LANE];
    logic [W_DZ2-1:0]          r_dz2  [N_LANE];
    logic [N_LANE-1:0]         r_rpos;

    logic                      r_s1_vld;
    logic [N_LANE-1:0]         r_s1_lv;
    logic [W_SQ-1:0]           r_h2c  [N_LANE];

    t_sq                       src    [SQ_STAGES][N_LANE];
    t_sq                       n_sq   [SQ_STAGES][N_LANE];
    t_sq                       r_sq   [SQ_STAGES][N_LANE];
    logic [N_LANE-1:0]         r_sq_lv [SQ_STAGES];
    logic [SQ_STAGES-1:0]      r_sq_vld;

    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            dz[l] = $signed({2'b00, i_tag})
                  - $signed({{(W_DZ-W_CRD){i_pos[l][47]}}, i_pos[l][47:32]});
            rr[l] = i_dist[l] * i_dist[l];
            dd[l] = dz[l] * dz[l];
            h2[l] = $signed({2'b00, r_r2[l]}) - $signed({1'b0, r_dz2[l]});
        end
    end

    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            src[0][l].n   = r_h2c[l];
            src[0][l].res = '0;
        end
        for (int j = 1; j < SQ_STAGES; j++) begin
            for (int l = 0; l < N_LANE; l++) begin
                src[j][l] = r_sq[j-1][l];
            end
        end
        for (int j = 0; j < SQ_STAGES; j++) begin
            for (int l = 0; l < N_LANE; l++) begin
                n_sq[j][l] = src[j][l];
                for (int k = 0; k < SQ_STEPS; k++) begin
                    n_sq[j][l] = sq_step(n_sq[j][l], j * SQ_STEPS + k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_sq_vld <= '0;
        end else begin
            r_s0_vld <= i_vld;
            r_s1_vld <= r_s0_vld;
            r_sq_vld <= {r_sq_vld[SQ_STAGES-2:0], r_s1_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < N_LANE; l++) begin
            r_r2[l]   <= rr[l][W_R2-1:0];
            r_dz2[l]  <= dd[l][W_DZ2-1:0];
            r_rpos[l] <= !i_dist[l][W_R-1] && (i_dist[l] != '0);
            // far below zero means the range is shorter than the height gap
            r_s1_lv[l] <= r_rpos[l] && (h2[l] >= -(W_H2'(NEG_LIMIT))) && (l < NUM_ANCHORS);
            r_h2c[l]   <= h2[l][W_H2-1] ? '0 : h2[l][W_SQ-1:0];
        end
        r_sq_lv[0] <= r_s1_lv;
        for (int j = 1; j < SQ_STAGES; j++) begin
            r_sq_lv[j] <= r_sq_lv[j-1];
        end
        for (int j = 0; j < SQ_STAGES; j++) begin
            for (int l = 0; l < N_LANE; l++) begin
                r_sq[j][l] <= n_sq[j][l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            o_hr[l] = r_sq[SQ_STAGES-1][l].res[W_HR-1:0];
        end
        o_side.vld  = r_sq_vld[SQ_STAGES-1];
        o_side.mask = r_sq_lv[SQ_STAGES-1];
    end

endmodule

FILE: sv/uxt_accum.sv
// Reference selection and accumulation of the 2x2 normal equations.
module uxt_accum import uxt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_front_side             i_side,
    input  logic [W_HR-1:0]         i_hr  [N_LANE],
    input  logic [W_POSREG-1:0]     i_pos [N_LANE],
    output t_acc_side               o_side,
    output logic signed [W_S-1:0]   o_s00,
    output logic signed [W_S-1:0]   o_s01,
    output logic signed [W_S-1:0]   o_s11,
    output logic signed [W_T-1:0]   o_t0,
    output logic signed [W_T-1:0]   o_t1
);

    logic signed [W_CRD-1:0]   crd_x [N_LANE];
    logic signed [W_CRD-1:0]   crd_y [N_LANE];
    logic signed [2*W_CRD-1:0] xx    [N_LANE];
    logic signed [2*W_CRD-1:0] yy    [N_LANE];
    logic [LANE_W-1:0]         ref_l;
    logic [CNT_W-1:0]          cnt;
    logic signed [W_CRD-1:0]   x0;
    logic signed [W_CRD-1:0]   y0;
    logic signed [W_C-1:0]     cc    [N_LANE];
    logic signed [W_S-1:0]     sum00, sum01, sum11;
    logic signed [W_T-1:0]     sum0, sum1;

    // stage 1
    t_acc_side                 r1_side;
    logic [LANE_W-1:0]         r1_ref;
    logic [N_LANE-1:0]         r1_en;
    logic signed [W_A-1:0]     r1_a   [N_LANE];
    logic signed [W_A-1:0]     r1_b   [N_LANE];
    logic [W_SQ-1:0]           r1_hsq [N_LANE];
    logic [W_Q-1:0]            r1_q   [N_LANE];
    // stage 2
    t_acc_side                 r2_side;
    logic [N_LANE-1:0]         r2_en;
    logic signed [W_A-1:0]     r2_a   [N_LANE];
    logic signed [W_A-1:0]     r2_b   [N_LANE];
    logic signed [W_C-1:0]     r2_c   [N_LANE];
    logic signed [W_AA-1:0]    r2_aa  [N_LANE];
    logic signed [W_AA-1:0]    r2_ab  [N_LANE];
    logic signed [W_AA-1:0]    r2_bb  [N_LANE];
    // stage 3
    t_acc_side                 r3_side;
    logic signed [W_AC-1:0]    r3_ac  [N_LANE];
    logic signed [W_AC-1:0]    r3_bc  [N_LANE];
    logic signed [W_S-1:0]     r3_s00, r3_s01, r3_s11;
    // stage 4
    t_acc_side                 r4_side;
    logic signed [W_S-1:0]     r4_s00, r4_s01, r4_s11;
    logic signed [W_T-1:0]     r4_t0, r4_t1;

    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            crd_x[l] = $signed(i_pos[l][15:0]);
            crd_y[l] = $signed(i_pos[l][31:16]);
            xx[l]    = crd_x[l] * crd_x[l];
            yy[l]    = crd_y[l] * crd_y[l];
        end
        // first valid anchor is the reference
        ref_l = '0;
        for (int l = N_LANE - 1; l >= 0; l--) begin
            if (i_side.mask[l]) begin
                ref_l = LANE_W'(l);
            end
        end
        cnt = CNT_W'($countones(i_side.mask));
        x0  = crd_x[ref_l];
        y0  = crd_y[ref_l];
    end

    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            cc[l] = $signed({2'b00, r1_hsq[r1_ref]}) - $signed({2'b00, r1_hsq[l]})
                  + $signed({2'b00, r1_q[l]}) - $signed({2'b00, r1_q[r1_ref]});
        end
        sum00 = '0;
        sum01 = '0;
        sum11 = '0;
        for (int l = 0; l < N_LANE; l++) begin
            sum00 = sum00 + W_S'(r2_aa[l]);
            sum01 = sum01 + W_S'(r2_ab[l]);
            sum11 = sum11 + W_S'(r2_bb[l]);
        end
        sum0 = '0;
        sum1 = '0;
        for (int l = 0; l < N_LANE; l++) begin
            sum0 = sum0 + W_T'(r3_ac[l]);
            sum1 = sum1 + W_T'(r3_bc[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.vld <= 1'b0;
            r2_side.vld <= 1'b0;
            r3_side.vld <= 1'b0;
            r4_side.vld <= 1'b0;
        end else begin
            r1_side.vld <= i_side.vld;
            r2_side.vld <= r1_side.vld;
            r3_side.vld <= r2_side.vld;
            r4_side.vld <= r3_side.vld;
        end

        r1_side.mask <= i_side.mask;
        r1_side.few  <= cnt < CNT_W'(MIN_ANCHORS);
        r1_ref       <= ref_l;
        for (int l = 0; l < N_LANE; l++) begin
            r1_en[l]  <= i_side.mask[l] && (LANE_W'(l) != ref_l);
            r1_a[l]   <= (W_A'(crd_x[l]) - W_A'(x0)) <<< 1;
            r1_b[l]   <= (W_A'(crd_y[l]) - W_A'(y0)) <<< 1;
            r1_hsq[l] <= W_SQ'(i_hr[l]) * W_SQ'(i_hr[l]);
            r1_q[l]   <= W_Q'(unsigned'(xx[l])) + W_Q'(unsigned'(yy[l]));
        end

        r2_side.mask <= r1_side.mask;
        r2_side.few  <= r1_side.few;
        r2_en        <= r1_en;
        for (int l = 0; l < N_LANE; l++) begin
            r2_a[l]  <= r1_a[l];
            r2_b[l]  <= r1_b[l];
            r2_c[l]  <= cc[l];
            r2_aa[l] <= r1_en[l] ? r1_a[l] * r1_a[l] : W_AA'(0);
            r2_ab[l] <= r1_en[l] ? r1_a[l] * r1_b[l] : W_AA'(0);
            r2_bb[l] <= r1_en[l] ? r1_b[l] * r1_b[l] : W_AA'(0);
        end

        r3_side.mask <= r2_side.mask;
        r3_side.few  <= r2_side.few;
        r3_s00       <= sum00;
        r3_s01       <= sum01;
        r3_s11       <= sum11;
        for (int l = 0; l < N_LANE; l++) begin
            r3_ac[l] <= r2_en[l] ? r2_a[l] * r2_c[l] : W_AC'(0);
            r3_bc[l] <= r2_en[l] ? r2_b[l] * r2_c[l] : W_AC'(0);
        end

        r4_side.mask <= r3_side.mask;
        r4_side.few  <= r3_side.few;
        r4_s00       <= r3_s00;
        r4_s01       <= r3_s01;
        r4_s11       <= r3_s11;
        r4_t0        <= sum0;
        r4_t1        <= sum1;
    end

    assign o_side = r4_side;
    assign o_s00  = r4_s00;
    assign o_s01  = r4_s01;
    assign o_s11  = r4_s11;
    assign o_t0   = r4_t0;
    assign o_t1   = r4_t1;

endmodule

FILE: sv/uxt_mul.sv
// Pipelined signed multiplier built from four partial products, sign-magnitude result.
module uxt_mul import uxt_pkg::*; (
    input  logic                   i_clk,
    input  logic signed [W_T-1:0]  i_a,
    input  logic signed [W_S-1:0]  i_b,
    output logic [W_MAG-1:0]       o_mag,
    output logic                   o_neg
);

    localparam int AL_W = MUL_SPLIT;
    localparam int AH_W = W_T - MUL_SPLIT;
    localparam int BH_W = W_S - MUL_SPLIT;

    logic [W_T-1:0]             r1_ma;
    logic [W_S-1:0]             r1_mb;
    logic                       r1_neg;

    logic [AL_W+AL_W-1:0]       r2_ll;
    logic [AL_W+BH_W-1:0]       r2_lh;
    logic [AH_W+AL_W-1:0]       r2_hl;
    logic [AH_W+BH_W-1:0]       r2_hh;
    logic                       r2_neg;

    logic [AH_W+AL_W:0]         r3_mid;
    logic [AL_W+AL_W-1:0]       r3_ll;
    logic [AH_W+BH_W-1:0]       r3_hh;
    logic                       r3_neg;

    logic [W_MAG-1:0]           r4_p;
    logic                       r4_neg;

    always_ff @(posedge i_clk) begin
        r1_ma  <= i_a[W_T-1] ? unsigned'(-i_a) : unsigned'(i_a);
        r1_mb  <= i_b[W_S-1] ? unsigned'(-i_b) : unsigned'(i_b);
        r1_neg <= i_a[W_T-1] ^ i_b[W_S-1];

        r2_ll  <= (AL_W+AL_W)'(r1_ma[AL_W-1:0]) * (AL_W+AL_W)'(r1_mb[AL_W-1:0]);
        r2_lh  <= (AL_W+BH_W)'(r1_ma[AL_W-1:0]) * (AL_W+BH_W)'(r1_mb[W_S-1:AL_W]);
        r2_hl  <= (AH_W+AL_W)'(r1_ma[W_T-1:AL_W]) * (AH_W+AL_W)'(r1_mb[AL_W-1:0]);
        r2_hh  <= (AH_W+BH_W)'(r1_ma[W_T-1:AL_W]) * (AH_W+BH_W)'(r1_mb[W_S-1:AL_W]);
        r2_neg <= r1_neg;

        r3_mid <= (AH_W+AL_W+1)'(r2_lh) + (AH_W+AL_W+1)'(r2_hl);
        r3_ll  <= r2_ll;
        r3_hh  <= r2_hh;
        r3_neg <= r2_neg;

        r4_p   <= W_MAG'(r3_ll) + (W_MAG'(r3_mid) << MUL_SPLIT)
                + (W_MAG'(r3_hh) << (2 * MUL_SPLIT));
        r4_neg <= r3_neg;
    end

    assign o_mag = r4_p;
    assign o_neg = r4_neg;

endmodule

FILE: sv/uxt_div.sv
// Pipelined restoring divider: truncated quotient saturated to the 18-bit output range.
module uxt_div import uxt_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [W_NUM-1:0]  i_num,
    input  logic signed [W_NUM-1:0]  i_den,
    output logic signed [W_OUT-1:0]  o_q
);

    logic [W_NUM-1:0]      r0_n, r0_d;
    logic                  r0_neg;
    logic [W_NUM-1:0]      r1_n, r1_d;
    logic                  r1_neg, r1_sat;

    logic [W_NUM-1:0]      src_n   [DIV_STAGES];
    logic [W_NUM-1:0]      src_d   [DIV_STAGES];
    logic [W_OUT-1:0]      src_q   [DIV_STAGES];
    logic [W_NUM-1:0]      nx_n    [DIV_STAGES];
    logic [W_OUT-1:0]      nx_q    [DIV_STAGES];
    logic [W_DIV-1:0]      dsh     [DIV_STAGES][DIV_STEPS];

    logic [W_NUM-1:0]      r_st_n   [DIV_STAGES];
    logic [W_NUM-1:0]      r_st_d   [DIV_STAGES];
    logic [W_OUT-1:0]      r_st_q   [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_st_neg;
    logic [DIV_STAGES-1:0] r_st_sat;

    logic [W_OUT:0]        qf;
    logic signed [W_OUT:0] sv;
    logic signed [W_OUT-1:0] r_q;

    always_comb begin
        src_n[0] = r1_n;
        src_d[0] = r1_d;
        src_q[0] = '0;
        for (int j = 1; j < DIV_STAGES; j++) begin
            src_n[j] = r_st_n[j-1];
            src_d[j] = r_st_d[j-1];
            src_q[j] = r_st_q[j-1];
        end
        for (int j = 0; j < DIV_STAGES; j++) begin
            nx_n[j] = src_n[j];
            nx_q[j] = src_q[j];
            for (int s = 0; s < DIV_STEPS; s++) begin
                dsh[j][s] = W_DIV'(src_d[j]) << (W_OUT - 1 - (j * DIV_STEPS + s));
                if (W_DIV'(nx_n[j]) >= dsh[j][s]) begin
                    nx_n[j] = nx_n[j] - dsh[j][s][W_NUM-1:0];
                    nx_q[j][W_OUT - 1 - (j * DIV_STEPS + s)] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        qf = r_st_sat[DIV_STAGES-1] ? ((W_OUT+1)'(1) << W_OUT)
                                    : {1'b0, r_st_q[DIV_STAGES-1]};
        if (r_st_neg[DIV_STAGES-1]) begin
            sv = (qf > (W_OUT+1)'(POS_MIN_MAG)) ? -$signed((W_OUT+1)'(POS_MIN_MAG))
                                                : -$signed(qf);
        end else begin
            sv = (qf > (W_OUT+1)'(POS_MAX)) ? $signed((W_OUT+1)'(POS_MAX)) : $signed(qf);
        end
    end

    always_ff @(posedge i_clk) begin
        r0_neg <= i_num[W_NUM-1] != i_den[W_NUM-1];
        r0_n   <= i_num[W_NUM-1] ? unsigned'(-i_num) : unsigned'(i_num);
        r0_d   <= i_den[W_NUM-1] ? unsigned'(-i_den) : unsigned'(i_den);

        r1_n   <= r0_n;
        r1_d   <= r0_d;
        r1_neg <= r0_neg;
        // quotient does not fit below 2^18: report the top value
        r1_sat <= W_DIV'(r0_n) >= (W_DIV'(r0_d) << W_OUT);

        for (int j = 0; j < DIV_STAGES; j++) begin
            r_st_n[j] <= nx_n[j];
            r_st_d[j] <= src_d[j];
            r_st_q[j] <= nx_q[j];
        end
        r_st_neg <= {r_st_neg[DIV_STAGES-2:0], r1_neg};
        r_st_sat <= {r_st_sat[DIV_STAGES-2:0], r1_sat};

        r_q <= sv[W_OUT-1:0];
    end

    assign o_q = r_q;

endmodule

FILE: sv/uwb_xy_trilateration.sv
// Top level of the UWB planar trilateration pipeline.
// Usage:
//   Pulse start with the four slant ranges on i_dist_a0..i_dist_a3; the set is
//   taken at any rising edge where start is high and busy is low. busy is held
//   low, so a new range set can be taken every cycle.
//   Each set yields one result: o_valid is high for one cycle with
//   o_pos_x_mm, o_pos_y_mm, o_solve_status and o_used_anchors on the ports.
//   The result passes through 6 register stages of projection and square
//   root, 4 of accumulation, 4 of split multiplication, 1 for the
//   determinant and 9 for the restoring dividers. Results leave in the
//   order the sets came in.
//   Anchor positions and tag height are written through i_cfg_we, i_cfg_idx
//   and i_cfg_data, by the user only while no transaction is in flight (not
//   enforced by the block); writes to indexes above 4 are dropped.
//   Reset (i_rst_n low, synchronous) empties the pipeline and loads the
//   default anchor layout and tag height. The receiver cannot stall: each
//   result must be taken in the cycle it is shown.
module uwb_xy_trilateration import uxt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [W_R-1:0]    i_dist_a0,
    input  logic signed [W_R-1:0]    i_dist_a1,
    input  logic signed [W_R-1:0]    i_dist_a2,
    input  logic signed [W_R-1:0]    i_dist_a3,
    input  logic                     i_cfg_we,
    input  logic [W_CFG_IDX-1:0]     i_cfg_idx,
    input  logic [W_POSREG-1:0]      i_cfg_data,
    output logic                     o_valid,
    output logic signed [W_OUT-1:0]  o_pos_x_mm,
    output logic signed [W_OUT-1:0]  o_pos_y_mm,
    output logic [1:0]               o_solve_status,
    output logic [N_LANE-1:0]        o_used_anchors
);

    logic [W_POSREG-1:0]     r_anchor [N_LANE];
    logic [W_TAG-1:0]        r_tag;

    logic signed [W_R-1:0]   rng [N_LANE];
    t_front_side             fr_side;
    logic [W_HR-1:0]         fr_hr [N_LANE];

    t_acc_side               acc_side;
    logic signed [W_S-1:0]   s00, s01, s11;
    logic signed [W_T-1:0]   t0, t1;

    logic [W_MAG-1:0]        m_t0s11, m_s01t1, m_t1s00, m_t0s01, m_s00s11, m_s01s01;
    logic                    g_t0s11, g_s01t1, g_t1s00, g_t0s01, g_s00s11, g_s01s01;

    logic signed [W_NUM-1:0] r_det, r_nx, r_ny;
    t_acc_side               r_line_a [LINE_A];
    t_side                   r_e;
    t_side                   r_line_b [LINE_B];
    logic                    det_small;

    logic signed [W_OUT-1:0] q_x, q_y;
    t_side                   out_side;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor[0] <= ANCHOR0_RST;
            r_anchor[1] <= ANCHOR1_RST;
            r_anchor[2] <= ANCHOR2_RST;
            r_anchor[3] <= ANCHOR3_RST;
            r_tag       <= TAG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ANCHOR0: r_anchor[0] <= i_cfg_data;
                REG_ANCHOR1: r_anchor[1] <= i_cfg_data;
                REG_ANCHOR2: r_anchor[2] <= i_cfg_data;
                REG_ANCHOR3: r_anchor[3] <= i_cfg_data;
                REG_TAG:     r_tag       <= i_cfg_data[W_TAG-1:0];
                default: begin
                end
            endcase
        end
    end

    assign rng[0] = i_dist_a0;
    assign rng[1] = i_dist_a1;
    assign rng[2] = i_dist_a2;
    assign rng[3] = i_dist_a3;

    uxt_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_dist  (rng),
        .i_pos   (r_anchor),
        .i_tag   (r_tag),
        .o_side  (fr_side),
        .o_hr    (fr_hr)
    );

    uxt_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (fr_side),
        .i_hr    (fr_hr),
        .i_pos   (r_anchor),
        .o_side  (acc_side),
        .o_s00   (s00),
        .o_s01   (s01),
        .o_s11   (s11),
        .o_t0    (t0),
        .o_t1    (t1)
    );

    uxt_mul u_mul_t0s11 (.i_clk(i_clk), .i_a(t0), .i_b(s11),
                         .o_mag(m_t0s11), .o_neg(g_t0s11));
    uxt_mul u_mul_s01t1 (.i_clk(i_clk), .i_a(t1), .i_b(s01),
                         .o_mag(m_s01t1), .o_neg(g_s01t1));
    uxt_mul u_mul_t1s00 (.i_clk(i_clk), .i_a(t1), .i_b(s00),
                         .o_mag(m_t1s00), .o_neg(g_t1s00));
    uxt_mul u_mul_t0s01 (.i_clk(i_clk), .i_a(t0), .i_b(s01),
                         .o_mag(m_t0s01), .o_neg(g_t0s01));
    uxt_mul u_mul_det0  (.i_clk(i_clk), .i_a(W_T'(s00)), .i_b(s11),
                         .o_mag(m_s00s11), .o_neg(g_s00s11));
    uxt_mul u_mul_det1  (.i_clk(i_clk), .i_a(W_T'(s01)), .i_b(s01),
                         .o_mag(m_s01s01), .o_neg(g_s01s01));

    // Cramer's rule
    always_ff @(posedge i_clk) begin
        r_det <= sgn_mag(m_s00s11, g_s00s11) - sgn_mag(m_s01s01, g_s01s01);
        r_nx  <= sgn_mag(m_t0s11, g_t0s11) - sgn_mag(m_s01t1, g_s01t1);
        r_ny  <= sgn_mag(m_t1s00, g_t1s00) - sgn_mag(m_t0s01, g_t0s01);
    end

    assign det_small = (r_det < W_NUM'(DET_MIN)) && (r_det > -(W_NUM'(DET_MIN)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LINE_A; i++) begin
                r_line_a[i] <= '0;
            end
            r_e <= '0;
            for (int i = 0; i < LINE_B; i++) begin
                r_line_b[i] <= '0;
            end
        end else begin
            r_line_a[0] <= acc_side;
            for (int i = 1; i < LINE_A; i++) begin
                r_line_a[i] <= r_line_a[i-1];
            end
            r_e.vld  <= r_line_a[LINE_A-1].vld;
            r_e.mask <= r_line_a[LINE_A-1].mask;
            priority if (r_line_a[LINE_A-1].few) begin
                r_e.status <= ST_FEW;
            end else if (det_small) begin
                r_e.status <= ST_SING;
            end else begin
                r_e.status <= ST_OK;
            end
            r_line_b[0] <= r_e;
            for (int i = 1; i < LINE_B; i++) begin
                r_line_b[i] <= r_line_b[i-1];
            end
        end
    end

    uxt_div u_div_x (.i_clk(i_clk), .i_num(r_nx), .i_den(r_det), .o_q(q_x));
    uxt_div u_div_y (.i_clk(i_clk), .i_num(r_ny), .i_den(r_det), .o_q(q_y));

    assign out_side       = r_line_b[LINE_B-1];
    assign o_valid        = out_side.vld;
    assign o_solve_status = out_side.status;
    assign o_used_anchors = out_side.mask;
    assign o_pos_x_mm     = (out_side.status == ST_OK) ? q_x : '0;
    assign o_pos_y_mm     = (out_side.status == ST_OK) ? q_y : '0;

    localparam int LATENCY = 6 + 4 + MUL_LAT + 1 + DIV_STAGES + 3;

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without a transaction accepted %0d cycles earlier", LATENCY);

    a_few_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_solve_status == ST_FEW) == ($countones(o_used_anchors) < MIN_ANCHORS)))
        else $error("too-few status disagrees with used anchor mask");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_solve_status != ST_OK) |-> (o_pos_x_mm == '0) && (o_pos_y_mm == '0))
        else $error("position not zero on failed solve");

endmodule
